// File: hw/rtl/pca_pkg.sv
// package: widths, types and register codes for the closest approach block
`timescale 1ns / 1ps
package pca_pkg;
  localparam int CoordW = 24;
  localparam int FracBits = 16;
  localparam int FracW = FracBits + 1;
  localparam int IndexW = 20;
  localparam int PeriodW = 16;
  localparam int TimeW = 36;
  localparam int MissW = 25;
  localparam int DistW = 52;
  localparam int ProdW = 54;
  localparam logic [IndexW-1:0] IndexMax = {IndexW{1'b1}};

  localparam logic [1:0] RegTargetX = 2'd0;
  localparam logic [1:0] RegTargetY = 2'd1;
  localparam logic [1:0] RegTargetZ = 2'd2;
  localparam logic [1:0] RegPeriod = 2'd3;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t tx;
    coord_t ty;
    coord_t tz;
    logic [PeriodW-1:0] period;
  } cfg_t;
endpackage

// File: hw/rtl/pca_regs.sv
// configuration register file on the apb-style port
`timescale 1ns / 1ps
module pca_regs (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  output pca_pkg::cfg_t cfg
);
  logic [1:0] idx;
  assign idx = paddr[3:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tx <= '0;
      cfg.ty <= '0;
      cfg.tz <= '0;
      cfg.period <= 16'd4000;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        pca_pkg::RegTargetX: cfg.tx <= pwdata[23:0];
        pca_pkg::RegTargetY: cfg.ty <= pwdata[23:0];
        pca_pkg::RegTargetZ: cfg.tz <= pwdata[23:0];
        pca_pkg::RegPeriod: cfg.period <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      pca_pkg::RegTargetX: prdata = {{8{cfg.tx[23]}}, cfg.tx};
      pca_pkg::RegTargetY: prdata = {{8{cfg.ty[23]}}, cfg.ty};
      pca_pkg::RegTargetZ: prdata = {{8{cfg.tz[23]}}, cfg.tz};
      pca_pkg::RegPeriod: prdata = {16'd0, cfg.period};
      default: prdata = '0;
    endcase
  end
endmodule

// File: hw/rtl/polyline_closest_approach.sv
// top level: sequencer, one shared multiply-accumulate and two shift-subtract units
//   channel | dir | handshake             | payload
//   s_axis  | in  | s_tvalid/s_tready     | s_tdata pos_x,pos_y,pos_z; s_tlast last_sample
//   m_axis  | out | m_tvalid/m_tready     | m_tdata miss,closest x/y/z,index,fraction,time
//   apb     | in  | psel/penable/pready   | pwdata target x/y/z, sample period
// a later sample runs dot and length steps, the check, the 16-step divide if the
// fraction needs it, then candidate, distance and compare; a first sample of a run
// goes straight to distance and compare. a flagged sample adds the square root,
// the time and output steps. the multiplier, divide and root steps set the rate.
// rst clears the stream state and registers. a finished result waits in the output
// register; the block only stalls in its output step while an earlier result is unread.
`timescale 1ns / 1ps
module polyline_closest_approach (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [71:0] s_tdata,   // pos_x, pos_y, pos_z
  input  logic s_tlast,          // last_sample
  output logic m_tvalid,
  input  logic m_tready,
  output logic [175:0] m_tdata,  // miss distance, closest point x/y/z, segment index,
                                 // segment fraction, time in us, zero fill
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  pca_pkg::cfg_t cfg;
  pca_regs u_regs (.clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg);

  localparam logic [3:0] S_IDLE = 4'd0, S_DOT = 4'd1, S_CHK = 4'd2, S_DIV = 4'd3,
    S_CAND = 4'd4, S_DIST = 4'd5, S_CMP = 4'd6, S_SQRT = 4'd7, S_T1 = 4'd8,
    S_T2 = 4'd9, S_OUT = 4'd10;
  logic [3:0] state;
  logic [4:0] step;

  logic have_prev, last;
  pca_pkg::coord_t prev [3];
  pca_pkg::coord_t cur [3];
  pca_pkg::coord_t cand [3];
  pca_pkg::coord_t best [3];
  logic [pca_pkg::IndexW-1:0] count, best_idx;
  logic [pca_pkg::FracW-1:0] frac, best_frac;
  logic [pca_pkg::DistW-1:0] best_d2;
  logic signed [pca_pkg::ProdW-1:0] acc_dot, acc_len, acc;
  logic [pca_pkg::ProdW-1:0] rem;
  logic [pca_pkg::MissW-1:0] root;
  logic [pca_pkg::TimeW+1:0] tacc;

  // shared multiplier
  logic signed [26:0] ma, mb;
  logic signed [53:0] mp;
  assign mp = ma * mb;

  logic [1:0] k;
  assign k = step[1:0];
  pca_pkg::coord_t tgt_k;
  always_comb begin
    unique case (k)
      2'd0: tgt_k = cfg.tx;
      2'd1: tgt_k = cfg.ty;
      default: tgt_k = cfg.tz;
    endcase
  end
  logic signed [24:0] dk, wk;
  assign dk = 25'(cur[k]) - 25'(prev[k]);
  assign wk = 25'(tgt_k) - 25'(prev[k]);

  // rounding of d*frac/2^16 toward plus infinity on ties
  logic signed [53:0] rs;
  assign rs = (mp + 54'sd32768) >>> pca_pkg::FracBits;

  // square root trial
  logic [pca_pkg::ProdW-1:0] sq_t, sq_rem_n;
  logic [pca_pkg::ProdW-1:0] sq_in;
  assign sq_t = {27'd0, root, 2'b01};
  assign sq_in = {rem[51:0], acc[53:52]};
  assign sq_rem_n = sq_in - sq_t;

  always_comb begin
    ma = '0; mb = '0;
    unique case (state)
      S_DOT: begin
        ma = 27'(dk);
        mb = step[2] ? 27'(dk) : 27'(wk);
      end
      S_CAND: begin
        ma = 27'(dk);
        mb = 27'(frac);
      end
      S_DIST: begin
        ma = 27'(25'(step[1:0] == 2'd3 ? best[0] : cand[k]) - 25'(tgt_k));
        mb = ma;
      end
      S_T1: begin
        ma = 27'(best_idx);
        mb = 27'(cfg.period);
      end
      S_T2: begin
        ma = 27'(best_frac);
        mb = 27'(cfg.period);
      end
      default: ;
    endcase
  end

  assign s_tready = (state == S_IDLE);
  logic [pca_pkg::ProdW-1:0] sub;
  assign sub = {rem[52:0], 1'b0} - acc_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      have_prev <= 1'b0;
      m_tvalid <= 1'b0;
      count <= '0;
      best_d2 <= '1;
      best_idx <= '0;
      best_frac <= '0;
      for (int i = 0; i < 3; i++) begin
        prev[i] <= '0;
        best[i] <= '0;
      end
    end else begin
      if (state == S_OUT && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (s_tvalid && s_tready) begin
          cur[0] <= s_tdata[23:0];
          cur[1] <= s_tdata[47:24];
          cur[2] <= s_tdata[71:48];
          last <= s_tlast;
          acc_dot <= '0;
          acc_len <= '0;
          frac <= '0;
          step <= '0;
          if (have_prev) state <= S_DOT;
          else begin
            best[0] <= s_tdata[23:0];
            best[1] <= s_tdata[47:24];
            best[2] <= s_tdata[71:48];
            cand[0] <= s_tdata[23:0];
            cand[1] <= s_tdata[47:24];
            cand[2] <= s_tdata[71:48];
            state <= S_DIST;
            acc <= '0;
          end
        end
        // steps 0..2 dot, 4..6 len2
        S_DOT: begin
          if (step[2]) acc_len <= acc_len + mp;
          else acc_dot <= acc_dot + mp;
          if (step == 5'd2) step <= 5'd4;
          else if (step == 5'd6) begin
            step <= '0;
            state <= S_CHK;
          end else step <= step + 5'd1;
        end
        S_CHK: begin
          if (acc_len == 0 || acc_dot <= 0) begin
            frac <= '0;
            state <= S_CAND;
          end else if (acc_dot >= acc_len) begin
            frac <= 17'd65536;
            state <= S_CAND;
          end else begin
            rem <= acc_dot;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (!sub[53]) begin
            rem <= sub;
            frac <= {frac[15:0], 1'b1};
          end else begin
            rem <= {rem[52:0], 1'b0};
            frac <= {frac[15:0], 1'b0};
          end
          if (step == 5'd15) begin
            step <= '0;
            state <= S_CAND;
          end else step <= step + 5'd1;
        end
        S_CAND: begin
          cand[k] <= 24'(54'(prev[k]) + rs);
          if (step == 5'd2) begin
            step <= '0;
            acc <= '0;
            state <= S_DIST;
          end else step <= step + 5'd1;
        end
        S_DIST: begin
          acc <= acc + mp;
          if (step == 5'd2) begin
            step <= '0;
            state <= S_CMP;
          end else step <= step + 5'd1;
        end
        S_CMP: begin
          if (!have_prev || acc[51:0] < best_d2) begin
            best_d2 <= acc[51:0];
            best[0] <= cand[0];
            best[1] <= cand[1];
            best[2] <= cand[2];
            best_idx <= have_prev ? count : '0;
            best_frac <= frac;
          end
          if (!have_prev) count <= '0;
          else if (count != pca_pkg::IndexMax) count <= count + 1'b1;
          have_prev <= 1'b1;
          prev[0] <= cur[0];
          prev[1] <= cur[1];
          prev[2] <= cur[2];
          if (last) begin
            // radicand sits two bits up so its lowest pair is taken in the final step
            acc <= ((!have_prev || acc[51:0] < best_d2) ? acc : 54'(best_d2)) << 2;
            rem <= '0;
            root <= '0;
            step <= '0;
            state <= S_SQRT;
          end else state <= S_IDLE;
        end
        // two bits of the radicand per step, 26 steps
        S_SQRT: begin
          acc <= acc << 2;
          if (sq_in >= sq_t) begin
            rem <= sq_rem_n;
            root <= {root[23:0], 1'b1};
          end else begin
            rem <= sq_in;
            root <= {root[23:0], 1'b0};
          end
          if (step == 5'd25) state <= S_T1;
          else step <= step + 5'd1;
        end
        S_T1: begin
          tacc <= 38'(mp);
          state <= S_T2;
        end
        S_T2: begin
          tacc <= tacc + 38'((mp + 54'sd32768) >>> pca_pkg::FracBits);
          state <= S_OUT;
        end
        // waits here while an earlier result is still unread
        S_OUT: if (!m_tvalid || m_tready) begin
          have_prev <= 1'b0;
          count <= '0;
          best_d2 <= '1;
          for (int i = 0; i < 3; i++) begin
            prev[i] <= '0;
            best[i] <= '0;
          end
          best_idx <= '0;
          best_frac <= '0;
          state <= S_IDLE;
          m_tdata <= {6'd0, tacc > 38'h0F_FFFF_FFFF ? 36'hF_FFFF_FFFF : tacc[35:0],
            best_frac, best_idx, best[2], best[1], best[0], root};
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: dv/polyline_closest_approach_test.sv
// testbench: closest approach of a sampled trajectory, checked against a built-in predictor
`timescale 1ns / 1ps
module polyline_closest_approach_test;
  localparam int CycleLimit = 3000000;
  localparam int Settle = 120;

  typedef struct {
    pca_pkg::coord_t x;
    pca_pkg::coord_t y;
    pca_pkg::coord_t z;
    bit last;
  } sample_t;

  typedef struct {
    logic [pca_pkg::MissW-1:0] miss;
    pca_pkg::coord_t cx;
    pca_pkg::coord_t cy;
    pca_pkg::coord_t cz;
    logic [pca_pkg::IndexW-1:0] idx;
    logic [pca_pkg::FracW-1:0] frac;
    logic [pca_pkg::TimeW-1:0] t_us;
  } approach_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [71:0] s_tdata = '0;   // pos_x, pos_y, pos_z
  logic s_tlast = 1'b0;        // last_sample
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [175:0] m_tdata;       // miss, closest x/y/z, index, fraction, time, zero fill
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  polyline_closest_approach u_top (.*);

  sample_t pending_samples[$];
  approach_t expected_approaches[$];
  sample_t offered;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int approaches_seen = 0;
  int hold_left = 0;
  bit hold_done = 0;
  longint cycles = 0;
  longint prev_stim[3] = '{0, 0, 0};

  // predictor state and register copy
  longint tgt[3] = '{0, 0, 0};
  longint period = 4000;
  bit have_prev = 0;
  longint prev[3];
  longint seg_count;
  longint best_d2;
  longint best_pt[3];
  longint best_idx;
  longint best_frac;

  initial forever #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic longint squared_miss(longint p[3]);
    longint acc;
    acc = 0;
    for (int k = 0; k < 3; k++) acc += (p[k] - tgt[k]) * (p[k] - tgt[k]);
    return acc;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic void clear_track();
    have_prev = 0;
    prev = '{0, 0, 0};
    seg_count = 0;
    best_d2 = 64'hF_FFFF_FFFF_FFFF;
    best_pt = '{0, 0, 0};
    best_idx = 0;
    best_frac = 0;
  endfunction

  function automatic void track_sample(sample_t s);
    longint c[3], d[3], cand[3];
    longint dot, len2, frac, dd, t;
    logic [127:0] num;
    approach_t r;
    c[0] = s.x;
    c[1] = s.y;
    c[2] = s.z;
    if (!have_prev) begin
      best_pt = c;
      best_d2 = squared_miss(c);
      best_idx = 0;
      best_frac = 0;
      seg_count = 0;
      have_prev = 1;
    end else begin
      dot = 0;
      len2 = 0;
      for (int k = 0; k < 3; k++) begin
        d[k] = c[k] - prev[k];
        len2 += d[k] * d[k];
        dot += (tgt[k] - prev[k]) * d[k];
      end
      frac = 0;
      if (len2 != 0 && dot > 0) begin
        if (dot >= len2) begin
          frac = 64'd1 << pca_pkg::FracBits;
        end else begin
          num = 128'(dot) << pca_pkg::FracBits;
          frac = longint'(num / 128'(len2));
        end
      end
      // round half towards plus infinity
      for (int k = 0; k < 3; k++)
        cand[k] = prev[k] + ((d[k] * frac + (64'sd1 << (pca_pkg::FracBits - 1)))
          >>> pca_pkg::FracBits);
      dd = squared_miss(cand);
      if (dd < best_d2) begin
        best_d2 = dd;
        best_pt = cand;
        best_idx = seg_count;
        best_frac = frac;
      end
      if (seg_count < longint'(pca_pkg::IndexMax)) seg_count++;
    end
    prev = c;
    if (s.last) begin
      t = best_idx * period + ((best_frac * period + (64'd1 << (pca_pkg::FracBits - 1)))
        >> pca_pkg::FracBits);
      if (t > 64'hF_FFFF_FFFF) t = 64'hF_FFFF_FFFF;
      r.miss = pca_pkg::MissW'(int_sqrt(best_d2));
      r.cx = pca_pkg::coord_t'(best_pt[0]);
      r.cy = pca_pkg::coord_t'(best_pt[1]);
      r.cz = pca_pkg::coord_t'(best_pt[2]);
      r.idx = pca_pkg::IndexW'(best_idx);
      r.frac = pca_pkg::FracW'(best_frac);
      r.t_us = pca_pkg::TimeW'(t);
      expected_approaches.insert(expected_approaches.size(), r);
      clear_track();
    end
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s expected %0d got %0d", name, want, got);
      errors++;
    end
  endfunction

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) track_sample(offered);
      if (!s_tvalid || s_tready) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = pending_samples.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {offered.z, offered.y, offered.x};
          s_tlast <= offered.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    approach_t w;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        approaches_seen++;
        if (expected_approaches.size() == 0) begin
          $error("result item with nothing expected");
          errors++;
        end else begin
          w = expected_approaches.pop_front();
          compare_field("miss_dist", 64'(w.miss), 64'(m_tdata[24:0]));
          compare_field("near_x", 64'(unsigned'(w.cx)), 64'(m_tdata[48:25]));
          compare_field("near_y", 64'(unsigned'(w.cy)), 64'(m_tdata[72:49]));
          compare_field("near_z", 64'(unsigned'(w.cz)), 64'(m_tdata[96:73]));
          compare_field("segment_index", 64'(w.idx), 64'(m_tdata[116:97]));
          compare_field("segment_fraction", 64'(w.frac), 64'(m_tdata[133:117]));
          compare_field("closest_time_us", 64'(w.t_us), 64'(m_tdata[169:134]));
        end
      end
      // one long hold-off so the block backs up onto its input
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else if (approaches_seen == 25 && !hold_done) begin
        hold_left <= 600;
        hold_done <= 1'b1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic write_reg(logic [1:0] code, longint value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {code, 2'b00};
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (code)
      pca_pkg::RegTargetX: tgt[0] = longint'(pca_pkg::coord_t'(value));
      pca_pkg::RegTargetY: tgt[1] = longint'(pca_pkg::coord_t'(value));
      pca_pkg::RegTargetZ: tgt[2] = longint'(pca_pkg::coord_t'(value));
      pca_pkg::RegPeriod: period = value & 64'hFFFF;
      default: ;
    endcase
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_samples.size() != 0 || s_tvalid || expected_approaches.size() != 0);
    // a sample without a flag leaves no result but may still be in flight
    repeat (Settle) @(posedge clk);
  endtask

  task automatic add_sample(longint x, longint y, longint z, bit last);
    sample_t s;
    s.x = pca_pkg::coord_t'(x);
    s.y = pca_pkg::coord_t'(y);
    s.z = pca_pkg::coord_t'(z);
    s.last = last;
    pending_samples.insert(pending_samples.size(), s);
  endtask

  function automatic longint clamp24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint full_coord();
    return longint'(pca_pkg::coord_t'($urandom));
  endfunction

  // one trajectory: wide random, near the target, or with repeated points
  task automatic add_trajectory(output int n);
    int flavour, spread;
    longint base[3], p[3];
    n = ($urandom_range(3) == 0) ? 1 : $urandom_range(12, 2);
    flavour = $urandom_range(9);
    spread = (flavour < 7) ? (1 << $urandom_range(18, 4)) : 4;
    for (int k = 0; k < 3; k++)
      base[k] = clamp24(tgt[k] + $signed($urandom_range(2 * spread)) - spread);
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 3; k++) begin
        if (flavour >= 8) p[k] = full_coord();
        else p[k] = clamp24(base[k] + $signed($urandom_range(2 * spread)) - spread);
      end
      if (flavour == 7 && $urandom_range(1) == 0 && i > 0) p = prev_stim;
      add_sample(p[0], p[1], p[2], i == n - 1);
      prev_stim = p;
    end
  endtask

  initial begin
    int produced, n;
    clear_track();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: reset registers, target at origin
    add_sample(5, -7, 3, 1);
    add_sample(40, 40, 40, 0);
    add_sample(40, 40, 40, 1);
    add_sample(8388607, 8388607, 8388607, 0);
    add_sample(-8388608, -8388608, -8388608, 1);
    add_sample(100, 0, 0, 0);
    add_sample(200, 0, 0, 1);
    add_sample(-300, 0, 0, 0);
    add_sample(-100, 0, 0, 1);
    add_sample(-3, 7, 1, 0);
    add_sample(5, -2, 4, 0);
    add_sample(11, 9, -6, 1);
    add_sample(-8388608, 8388607, -8388608, 0);
    add_sample(8388607, -8388608, 8388607, 1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(pca_pkg::RegTargetX, $signed($urandom_range(200000)) - 100000);
          write_reg(pca_pkg::RegTargetY, $signed($urandom_range(200000)) - 100000);
          write_reg(pca_pkg::RegTargetZ, $signed($urandom_range(200000)) - 100000);
          write_reg(pca_pkg::RegPeriod, 4000);
        end
        1: begin
          write_reg(pca_pkg::RegTargetX, 8388607);
          write_reg(pca_pkg::RegTargetY, 8388607);
          write_reg(pca_pkg::RegTargetZ, 8388607);
          write_reg(pca_pkg::RegPeriod, 65535);
        end
        2: begin
          write_reg(pca_pkg::RegTargetX, -8388608);
          write_reg(pca_pkg::RegTargetY, -8388608);
          write_reg(pca_pkg::RegTargetZ, -8388608);
          write_reg(pca_pkg::RegPeriod, 0);
        end
        3: begin
          write_reg(pca_pkg::RegTargetX, 0);
          write_reg(pca_pkg::RegTargetY, -8388608);
          write_reg(pca_pkg::RegTargetZ, 8388607);
          write_reg(pca_pkg::RegPeriod, 1);
        end
        default: begin
          write_reg(pca_pkg::RegTargetX, full_coord());
          write_reg(pca_pkg::RegTargetY, full_coord());
          write_reg(pca_pkg::RegTargetZ, full_coord());
          write_reg(pca_pkg::RegPeriod, $urandom_range(65535));
        end
      endcase
      if (ph < 2) begin
        send_idle_pct = 24;
        recv_idle_pct = 65;
      end else if (ph < 4) begin
        send_idle_pct = 65;
        recv_idle_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      produced = 0;
      while (produced < 315) begin
        add_trajectory(n);
        produced += n;
      end
      drain();
    end

    if (expected_approaches.size() != 0) begin
      $error("%0d results never arrived", expected_approaches.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
